// ----- sv/proximity_pair_join_defines.svh -----
// assertion macros for the proximity pair join checker
// expects clk and rst_n in the scope where the macros are used
`ifndef PROXIMITY_PAIR_JOIN_DEFINES_SVH
`define PROXIMITY_PAIR_JOIN_DEFINES_SVH

// checked only outside reset
`define PPJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PPJ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/ppj_pkg.sv -----
// shared constants for the proximity pair join block
// used by proximity_pair_join, ppj_checker and the testbench, no dependencies
`default_nettype none

package ppj_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 16;

  localparam int LIMIT_W    = 17;
  localparam int OPCODE_W   = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_BIT = 2;

  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  localparam logic REG_MAX_DISTANCE    = 1'b0;
  localparam logic REG_MAX_HEIGHT_DIFF = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

`default_nettype wire

// ----- sv/proximity_pair_join.sv -----
// proximity pair join top level: reference table memory, scan pipeline, apb registers
// depends on ppj_pkg
//
// Keeps up to TABLE_DEPTH reference points in a single-port-read synchronous memory
// and joins each query request against them in load order. Clear, load and unused
// opcodes give one result each. A query reads each stored entry through the read
// register, difference and square stages, then closes the scan; an empty table closes
// it with no read, and a stalled result side holds it. It gives one result per
// matching entry, or one not-valid result when nothing matches. The memory read port
// sets the rate: one entry per cycle while the result side does not stall. No clearing
// pass is needed after reset, since only entries below the fill count are ever read.
// A new request is taken only when no query is in flight.
`default_nettype none

module proximity_pair_join #(
  parameter int TABLE_DEPTH = ppj_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_WIDTH = ppj_pkg::COORD_WIDTH_DEF,
  parameter int ID_WIDTH    = ppj_pkg::ID_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ppj_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic signed [COORD_WIDTH-1:0]      in_coord_x,
  input  logic signed [COORD_WIDTH-1:0]      in_coord_y,
  input  logic signed [COORD_WIDTH-1:0]      in_coord_z,
  input  logic [ID_WIDTH-1:0]                in_point_id,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_status,
  output logic                               out_pair_valid,
  output logic [ID_WIDTH-1:0]                out_first_id,
  output logic [ID_WIDTH-1:0]                out_second_id,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppj_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ppj_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ppj_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  import ppj_pkg::*;

  localparam int AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int EW       = 3 * COORD_WIDTH + ID_WIDTH;
  localparam int SQ_W     = 2 * COORD_WIDTH;
  localparam int D2_W     = SQ_W + 1;
  localparam int LIM2_W   = 2 * LIMIT_W;
  localparam int CMP_W    = (D2_W > LIM2_W) ? D2_W : LIM2_W;
  localparam int DZ_CMP_W = (COORD_WIDTH > LIMIT_W) ? COORD_WIDTH : LIMIT_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  function automatic logic [COORD_WIDTH-1:0] abs_diff(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [COORD_WIDTH:0] d;
    d = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    return (d < 0) ? COORD_WIDTH'(-d) : COORD_WIDTH'(d);
  endfunction

  // configuration
  logic [LIMIT_W-1:0] max_dist_r;
  logic [LIMIT_W-1:0] max_hdiff_r;
  logic [LIM2_W-1:0]  lim2_r;
  logic               cfg_wr;

  // control
  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic            v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            adv, issue, q_latch, match, out_load;

  // memory
  logic [EW-1:0]   mem [TABLE_DEPTH];
  logic [EW-1:0]   rd_data_r;
  logic            mem_we, mem_re;

  // datapath
  logic signed [COORD_WIDTH-1:0] q_x_r, q_y_r, q_z_r;
  logic [ID_WIDTH-1:0]           q_id_r;
  logic [COORD_WIDTH-1:0]        dx_r, dy_r, dz_r;
  logic [ID_WIDTH-1:0]           id2_r, id3_r;
  logic [SQ_W-1:0]               sx_r, sy_r;
  logic                          dz_ok_r;
  logic [CMP_W-1:0]              d2;
  logic [ID_WIDTH-1:0]           pend_id_r, pend_id_nxt;

  logic                out_status_r, out_status_nxt;
  logic                out_pair_r, out_pair_nxt;
  logic [ID_WIDTH-1:0] out_first_r, out_first_nxt;
  logic [ID_WIDTH-1:0] out_second_r, out_second_nxt;
  logic                out_last_r, out_last_nxt;

  logic signed [COORD_WIDTH-1:0] e_x, e_y, e_z;
  logic [ID_WIDTH-1:0]           e_id;

  // apb registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r  <= '0;
      max_hdiff_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[CFG_IDX_BIT])
        REG_MAX_DISTANCE:    max_dist_r  <= pwdata[LIMIT_W-1:0];
        REG_MAX_HEIGHT_DIFF: max_hdiff_r <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_IDX_BIT])
      REG_MAX_DISTANCE:    prdata = CFG_DATA_W'(max_dist_r);
      REG_MAX_HEIGHT_DIFF: prdata = CFG_DATA_W'(max_hdiff_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    lim2_r <= LIM2_W'(max_dist_r) * LIM2_W'(max_dist_r);
  end

  // reference table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= {in_coord_x, in_coord_y, in_coord_z, in_point_id};
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_cnt_r[AW-1:0]];
    end
  end

  assign e_x  = rd_data_r[EW-1 -: COORD_WIDTH];
  assign e_y  = rd_data_r[EW-COORD_WIDTH-1 -: COORD_WIDTH];
  assign e_z  = rd_data_r[ID_WIDTH+COORD_WIDTH-1 -: COORD_WIDTH];
  assign e_id = rd_data_r[ID_WIDTH-1:0];

  // scan pipeline
  always_ff @(posedge clk) begin
    if (q_latch) begin
      q_x_r  <= in_coord_x;
      q_y_r  <= in_coord_y;
      q_z_r  <= in_coord_z;
      q_id_r <= in_point_id;
    end
    if (adv) begin
      dx_r    <= abs_diff(q_x_r, e_x);
      dy_r    <= abs_diff(q_y_r, e_y);
      dz_r    <= abs_diff(q_z_r, e_z);
      id2_r   <= e_id;
      sx_r    <= SQ_W'(dx_r) * SQ_W'(dx_r);
      sy_r    <= SQ_W'(dy_r) * SQ_W'(dy_r);
      dz_ok_r <= DZ_CMP_W'(dz_r) < DZ_CMP_W'(max_hdiff_r);
      id3_r   <= id2_r;
    end
  end

  assign d2    = CMP_W'(sx_r) + CMP_W'(sy_r);
  assign match = v3_r && dz_ok_r && (d2 < CMP_W'(lim2_r));

  // control
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && adv;
  assign issue    = (state_r == S_SCAN) && (rd_cnt_r != n_r);
  assign mem_re   = adv && issue;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_cnt_nxt     = rd_cnt_r;
    n_nxt          = n_r;
    v1_nxt         = v1_r;
    v2_nxt         = v2_r;
    v3_nxt         = v3_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_pair_nxt   = out_pair_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    q_latch        = 1'b0;
    if (adv) begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            out_status_nxt = STATUS_OK;
            out_pair_nxt   = 1'b0;
            out_first_nxt  = '0;
            out_second_nxt = '0;
            out_last_nxt   = 1'b1;
            case (in_opcode)
              OP_CLEAR: begin
                count_nxt = '0;
                out_load  = 1'b1;
              end
              OP_LOAD: begin
                out_load = 1'b1;
                if (count_r == DEPTH_CNT) begin
                  out_status_nxt = STATUS_FULL;
                end else begin
                  mem_we    = 1'b1;
                  count_nxt = count_r + CNT_W'(1);
                end
              end
              OP_QUERY: begin
                q_latch    = 1'b1;
                n_nxt      = count_r;
                rd_cnt_nxt = '0;
                v1_nxt     = 1'b0;
                v2_nxt     = 1'b0;
                v3_nxt     = 1'b0;
                pend_v_nxt = 1'b0;
                state_nxt  = S_SCAN;
              end
              default: begin
                out_load = 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_cnt_nxt = issue ? rd_cnt_r + CNT_W'(1) : rd_cnt_r;
          v1_nxt     = issue;
          v2_nxt     = v1_r;
          v3_nxt     = v2_r;
          if (match) begin
            if (pend_v_r) begin
              out_load       = 1'b1;
              out_status_nxt = STATUS_OK;
              out_pair_nxt   = 1'b1;
              out_first_nxt  = q_id_r;
              out_second_nxt = pend_id_r;
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = id3_r;
          end else if (!issue && !v1_r && !v2_r && !v3_r) begin
            out_load       = 1'b1;
            out_status_nxt = STATUS_OK;
            out_pair_nxt   = pend_v_r;
            out_first_nxt  = q_id_r;
            out_second_nxt = pend_v_r ? pend_id_r : '0;
            out_last_nxt   = 1'b1;
            pend_v_nxt     = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      n_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      n_r         <= n_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r    <= pend_id_nxt;
    out_status_r <= out_status_nxt;
    out_pair_r   <= out_pair_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_pair_valid = out_pair_r;
  assign out_first_id   = out_first_r;
  assign out_second_id  = out_second_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

// ----- sv/ppj_checker.sv -----
// port-level checks for proximity_pair_join, attached by bind
// depends on ppj_pkg and proximity_pair_join_defines.svh
`default_nettype none
`include "proximity_pair_join_defines.svh"

module ppj_checker #(
  parameter int ID_WIDTH = ppj_pkg::ID_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [ppj_pkg::OPCODE_W-1:0] in_opcode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_status,
  input logic                         out_pair_valid,
  input logic [ID_WIDTH-1:0]          out_first_id,
  input logic [ID_WIDTH-1:0]          out_second_id,
  input logic                         out_last,
  input logic                         pready
);

  import ppj_pkg::*;

  `PPJ_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
  `PPJ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_first_id) && $stable(out_second_id) && $stable(out_pair_valid) && $stable(out_last) && $stable(out_status), "stalled result changed")
  `PPJ_ASSERT(a_query_blocks, in_valid && in_ready && in_opcode == OP_QUERY |=> !in_ready, "request taken during query")
  `PPJ_ASSERT(a_nopair_last, out_valid && !out_pair_valid |-> out_last, "non-pair result not last")
  `PPJ_ASSERT(a_full_alone, out_valid && out_status |-> !out_pair_valid && out_last, "full status on pair result")

endmodule

bind proximity_pair_join ppj_checker #(.ID_WIDTH(ID_WIDTH)) u_ppj_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_opcode      (in_opcode),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_pair_valid (out_pair_valid),
  .out_first_id   (out_first_id),
  .out_second_id  (out_second_id),
  .out_last       (out_last),
  .pready         (pready)
);

`default_nettype wire

// ----- sim/proximity_pair_join_test.sv -----
// self-checking testbench for proximity_pair_join: directed table, then clustered random
// load/query sequences checked against an in-bench join predictor; depends on ppj_pkg
`timescale 1ns / 1ps

module proximity_pair_join_test;
  import ppj_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int CW = COORD_WIDTH_DEF;
  localparam int IW = ID_WIDTH_DEF;
  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int DIR_ROWS = 16;
  localparam int DIR_SPLIT = 8;
  localparam int PHASES = 9;
  localparam int FULL_PHASE = 3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [IW-1:0] id;
  } point_req_t;

  typedef struct packed {
    logic status;
    logic pair_valid;
    logic [IW-1:0] first_id;
    logic [IW-1:0] second_id;
    logic last;
  } join_result_t;

  typedef struct packed {
    point_req_t req;
    logic typed;
    join_result_t res;
  } dir_row_t;

  localparam join_result_t RES_DONE = '{STATUS_OK, 1'b0, 16'h0, 16'h0, 1'b1};

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [OPCODE_W-1:0] in_opcode;
  logic signed [CW-1:0] in_coord_x;
  logic signed [CW-1:0] in_coord_y;
  logic signed [CW-1:0] in_coord_z;
  logic [IW-1:0] in_point_id;
  logic out_valid;
  logic out_ready;
  logic out_status;
  logic out_pair_valid;
  logic [IW-1:0] out_first_id;
  logic [IW-1:0] out_second_id;
  logic out_last;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  proximity_pair_join dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_point_id(in_point_id),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_pair_valid(out_pair_valid), .out_first_id(out_first_id),
    .out_second_id(out_second_id), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // join predictor state
  logic signed [CW-1:0] ref_x [DEPTH];
  logic signed [CW-1:0] ref_y [DEPTH];
  logic signed [CW-1:0] ref_z [DEPTH];
  logic [IW-1:0] ref_id [DEPTH];
  int ref_count;
  logic [LIMIT_W-1:0] limit_dist;
  logic [LIMIT_W-1:0] limit_height;

  join_result_t expected_results[$];
  dir_row_t dir_table [DIR_ROWS];

  int errors;
  int cycles;
  int requests_sent;
  int results_seen;
  int pairs_seen;
  int limit_writes;
  bit gaps_on;
  bit stalls_on;
  bit hold_off_req;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic join_request(input point_req_t r, input bit typed, input join_result_t tr);
    join_result_t res;
    longint ax, ay, az, bx, by, bz, d2, lim2, dz, lim_h;
    int hits;
    res = RES_DONE;
    hits = 0;
    case (r.opcode)
      OP_CLEAR: ref_count = 0;
      OP_LOAD: begin
        if (ref_count >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          ref_x[ref_count] = r.x;
          ref_y[ref_count] = r.y;
          ref_z[ref_count] = r.z;
          ref_id[ref_count] = r.id;
          ref_count++;
        end
      end
      OP_QUERY: begin
        lim2 = longint'(limit_dist);
        lim2 = lim2 * lim2;
        lim_h = longint'(limit_height);
        ax = longint'(r.x);
        ay = longint'(r.y);
        az = longint'(r.z);
        for (int j = 0; j < ref_count; j++) begin
          bx = longint'(ref_x[j]);
          by = longint'(ref_y[j]);
          bz = longint'(ref_z[j]);
          d2 = (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
          dz = (az > bz) ? az - bz : bz - az;
          if (d2 < lim2 && dz < lim_h) begin
            if (!typed) expected_results.push_back('{STATUS_OK, 1'b1, r.id, ref_id[j], 1'b0});
            hits++;
          end
        end
        if (hits == 0) begin
          res.first_id = r.id;
        end else if (!typed) begin
          expected_results[$].last = 1'b1;
        end
      end
      default: ;
    endcase
    if (typed) expected_results.push_back(tr);
    else if (hits == 0) expected_results.push_back(res);
  endtask

  task automatic send_request(input point_req_t r, input bit typed = 1'b0,
                              input join_result_t tr = RES_DONE);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= r.opcode;
    in_coord_x <= r.x;
    in_coord_y <= r.y;
    in_coord_z <= r.z;
    in_point_id <= r.id;
    do @(posedge clk); while (in_ready !== 1'b1);
    join_request(r, typed, tr);
    requests_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic idx, input int unsigned value);
    logic [CFG_ADDR_W-1:0] a;
    a = '0;
    a[CFG_IDX_BIT] = idx;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_MAX_DISTANCE) limit_dist = LIMIT_W'(value);
    else limit_height = LIMIT_W'(value);
    limit_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] near(input int center, input int spread);
    return CW'(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp, act);
    end
  endtask

  always @(posedge clk) begin
    join_result_t e;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (out_pair_valid === 1'b1) pairs_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %b %b %h %h %b", $time,
                 out_status, out_pair_valid, out_first_id, out_second_id, out_last);
      end else begin
        e = expected_results.pop_front();
        check_field("status", 32'(e.status), 32'(out_status));
        check_field("pair_valid", 32'(e.pair_valid), 32'(out_pair_valid));
        check_field("first_id", 32'(e.first_id), 32'(out_first_id));
        check_field("second_id", 32'(e.second_id), 32'(out_second_id));
        check_field("last", 32'(e.last), 32'(out_last));
      end
    end
  end

  always begin
    @(negedge clk);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      out_ready <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    point_req_t r;
    int unsigned dist_set [PHASES];
    int unsigned height_set [PHASES];
    int cx, cy, cz, sxy, sz, n_load, n_query;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_CLEAR;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    in_point_id = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    requests_sent = 0;
    results_seen = 0;
    pairs_seen = 0;
    limit_writes = 0;
    ref_count = 0;
    limit_dist = '0;
    limit_height = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_off_req = 1'b0;

    dist_set = '{0, 131071, 5, 2000, 300, 40, 1, 12000, 0};
    height_set = '{131071, 0, 3, 1000, 200, 40, 1, 131071, 0};

    dir_table = '{
      '{'{OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF}, 1'b1,
        '{STATUS_OK, 1'b0, 16'hFFFF, 16'h0, 1'b1}},
      '{'{OP_LOAD, 16'h8000, 16'h8000, 16'h8000, 16'h0000}, 1'b1, RES_DONE},
      '{'{OP_LOAD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF}, 1'b1, RES_DONE},
      '{'{OP_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0001}, 1'b1, RES_DONE},
      // zero limits never match
      '{'{OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0005}, 1'b1,
        '{STATUS_OK, 1'b0, 16'h0005, 16'h0, 1'b1}},
      '{'{OP_UNUSED, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hABCD}, 1'b1, RES_DONE},
      '{'{OP_QUERY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h00FF}, 1'b1,
        '{STATUS_OK, 1'b0, 16'h00FF, 16'h0, 1'b1}},
      '{'{OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, RES_DONE},
      // limits at maximum from here on, table empty after clear
      '{'{OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h1234}, 1'b1,
        '{STATUS_OK, 1'b0, 16'h1234, 16'h0, 1'b1}},
      '{'{OP_LOAD, 16'h8000, 16'h8000, 16'h8000, 16'h0AAA}, 1'b1, RES_DONE},
      '{'{OP_LOAD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h5555}, 1'b1, RES_DONE},
      '{'{OP_LOAD, 16'h0001, 16'hFFFF, 16'h0000, 16'h0002}, 1'b1, RES_DONE},
      '{'{OP_QUERY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF}, 1'b0, RES_DONE},
      '{'{OP_QUERY, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000}, 1'b0, RES_DONE},
      '{'{OP_UNUSED, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, RES_DONE},
      '{'{OP_QUERY, 16'h7FFF, 16'h8000, 16'h8000, 16'h8001}, 1'b0, RES_DONE}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_SPLIT) begin
        wait_idle();
        write_limit(REG_MAX_DISTANCE, 131071);
        write_limit(REG_MAX_HEIGHT_DIFF, 131071);
      end
      send_request(dir_table[i].req, dir_table[i].typed, dir_table[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == PHASES - 1) begin
        dist_set[ph] = $urandom_range(0, 131071);
        height_set[ph] = $urandom_range(0, 131071);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      write_limit(REG_MAX_DISTANCE, dist_set[ph]);
      write_limit(REG_MAX_HEIGHT_DIFF, height_set[ph]);
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
      cz = int'($urandom_range(0, 65535)) - 32768;
      if (ph == FULL_PHASE) begin
        sxy = 600;
        sz = 300;
        n_load = DEPTH + 3;
        n_query = 4;
      end else begin
        sxy = (dist_set[ph] > 10000) ? 20000 : int'(dist_set[ph]) * 2 + 3;
        sz = (height_set[ph] > 10000) ? 20000 : int'(height_set[ph]) * 2 + 3;
        n_load = $urandom_range(0, 14);
        n_query = $urandom_range(4, 10);
      end
      if (ph == FULL_PHASE || $urandom_range(0, 3) != 0) begin
        r = '{OP_CLEAR, CW'($urandom), CW'($urandom), CW'($urandom), IW'($urandom)};
        send_request(r);
      end
      for (int k = 0; k < n_load + n_query; k++) begin
        if (k == n_load && ph == FULL_PHASE) hold_off_req = 1'b1;
        r = '{(k < n_load) ? OP_LOAD : OP_QUERY, near(cx, sxy), near(cy, sxy), near(cz, sz),
              IW'($urandom)};
        // noise and broken sequences
        if (ph != FULL_PHASE && $urandom_range(0, 7) == 0)
          r = '{OPCODE_W'($urandom_range(0, 3)), CW'($urandom), CW'($urandom),
                CW'($urandom), IW'($urandom)};
        send_request(r);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("summary: %0d requests, %0d results checked (%0d pairs), %0d limit writes",
             requests_sent, results_seen, pairs_seen, limit_writes);
    $display("summary: zero and maximum limits, full table with dropped loads, long output hold");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- proximity_pair_join.f -----
+incdir+sv
sv/ppj_pkg.sv
sv/proximity_pair_join.sv
sv/ppj_checker.sv
sim/proximity_pair_join_test.sv
